>>> rtl/psfp_pkg.sv
// Shared constants and types for the particle sensor frame parser.
package psfp_pkg;

    // Frame geometry.
    localparam int FRAME_BYTES   = 32;
    localparam int READING_COUNT = 12;

    // The checksum covers every byte ahead of the two-byte trailer.
    localparam int SUM_END           = FRAME_BYTES - 2;
    localparam int FIRST_READING_POS = 4;
    localparam int RD_END            = FIRST_READING_POS + 2 * READING_COUNT;

    // Signal widths.
    localparam int COUNT_W = $clog2(FRAME_BYTES);
    localparam int IDX_W   = (READING_COUNT > 1) ? $clog2(READING_COUNT) : 1;
    localparam int CH_W    = 4;
    localparam int VAL_W   = 16;

    // Header bytes.
    localparam logic [7:0] HDR_FIRST  = 8'h42;
    localparam logic [7:0] HDR_SECOND = 8'h4D;

    // Parser phases.
    typedef enum logic [1:0] {
        PH_HUNT,
        PH_HDR,
        PH_BODY,
        PH_EMIT
    } phase_t;

endpackage

>>> rtl/psfp_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module psfp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 12
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic                                    re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> rtl/particle_sensor_frame_parser_core.sv
// Top level of the particle sensor frame parser: header hunt, frame sum and reading burst.
// A bad frame's result is registered in the cycle after the last trailer byte is taken. A
// good frame's readings pass the phase register, read port and output register; each read
// waits for the prior read's data. Throughput: one byte per cycle while parsing, but a
// closing byte waits while the output register is busy, and no bytes are taken until
// the last reading is read. Reset (rst_n low, asynchronous) returns to the header hunt.
module particle_sensor_frame_parser_core (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [7:0]                rx_byte,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [psfp_pkg::CH_W-1:0] channel,
    output logic [psfp_pkg::VAL_W-1:0] reading,
    output logic                      checksum_good,
    output logic                      last_of_frame
);
    import psfp_pkg::*;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(READING_COUNT - 1);

    phase_t              phase_reg, phase_next;
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic [VAL_W-1:0]    sum_reg, sum_next;
    logic [7:0]          high_reg, high_next;
    logic [IDX_W-1:0]    rd_idx_reg, rd_idx_next;
    logic [IDX_W-1:0]    pend_idx_reg;
    logic                rd_pend_reg;
    logic                out_valid_reg, out_valid_next;
    logic [CH_W-1:0]     ch_reg, ch_next;
    logic [VAL_W-1:0]    val_reg, val_next;
    logic                good_reg, good_next;
    logic                last_reg, last_next;

    logic                accept;
    logic                at_end;
    logic                sum_ok;
    logic                issue;
    logic [COUNT_W-1:0]  off;
    logic                ram_we;
    logic [IDX_W-1:0]    ram_waddr;
    logic [VAL_W-1:0]    ram_wdata;
    logic [VAL_W-1:0]    ram_rdata;

    // The next byte closes the frame.
    assign at_end = (phase_reg == PH_BODY) && (int'(count_reg) + 1 >= FRAME_BYTES);
    assign sum_ok = ({high_reg, rx_byte} == sum_reg);

    // Hold off a closing byte while the output register is still occupied.
    assign in_ready = (phase_reg != PH_EMIT) && !(out_valid_reg && at_end);
    assign accept   = in_valid && in_ready;

    // Start a memory read when the output register will be free for its data.
    assign issue = (phase_reg == PH_EMIT) && !rd_pend_reg && (!out_valid_reg || out_ready);

    assign off = count_reg - COUNT_W'(FIRST_READING_POS);

    // Next phase.
    always_comb
    begin
        phase_next = phase_reg;
        case (phase_reg)
            PH_HUNT:
            begin
                if (accept && rx_byte == HDR_FIRST)
                begin
                    phase_next = PH_HDR;
                end
            end
            PH_HDR:
            begin
                if (accept)
                begin
                    if (rx_byte == HDR_SECOND)
                    begin
                        phase_next = PH_BODY;
                    end
                    else if (rx_byte != HDR_FIRST)
                    begin
                        phase_next = PH_HUNT;
                    end
                end
            end
            PH_BODY:
            begin
                if (accept && at_end)
                begin
                    phase_next = sum_ok ? PH_EMIT : PH_HUNT;
                end
            end
            PH_EMIT:
            begin
                if (issue && rd_idx_reg == LAST_IDX)
                begin
                    phase_next = PH_HUNT;
                end
            end
            default:
            begin
                phase_next = PH_HUNT;
            end
        endcase
    end

    // Frame datapath, memory write and output register loading.
    always_comb
    begin
        count_next     = count_reg;
        sum_next       = sum_reg;
        high_next      = high_reg;
        rd_idx_next    = rd_idx_reg;
        ram_we         = 1'b0;
        ram_waddr      = IDX_W'(off >> 1);
        ram_wdata      = {high_reg, rx_byte};
        out_valid_next = out_valid_reg && !out_ready;
        ch_next        = ch_reg;
        val_next       = val_reg;
        good_next      = good_reg;
        last_next      = last_reg;

        if (accept && phase_reg == PH_HDR && rx_byte == HDR_SECOND)
        begin
            sum_next   = VAL_W'(HDR_FIRST) + VAL_W'(HDR_SECOND);
            count_next = COUNT_W'(2);
        end

        if (accept && phase_reg == PH_BODY)
        begin
            if (at_end)
            begin
                count_next  = '0;
                rd_idx_next = '0;
                // A bad frame reports a single flagged result.
                if (!sum_ok)
                begin
                    out_valid_next = 1'b1;
                    ch_next        = '0;
                    val_next       = '0;
                    good_next      = 1'b0;
                    last_next      = 1'b1;
                end
            end
            else
            begin
                count_next = count_reg + COUNT_W'(1);
                if (int'(count_reg) < SUM_END)
                begin
                    sum_next = sum_reg + VAL_W'(rx_byte);
                    if (int'(count_reg) >= FIRST_READING_POS && int'(count_reg) < RD_END)
                    begin
                        if (!off[0])
                        begin
                            high_next = rx_byte;
                        end
                        else if (int'(off >> 1) < READING_COUNT)
                        begin
                            ram_we = 1'b1;
                        end
                    end
                end
                else if (int'(count_reg) == SUM_END)
                begin
                    high_next = rx_byte;
                end
            end
        end

        if (issue)
        begin
            rd_idx_next = rd_idx_reg + IDX_W'(1);
        end

        // Memory data lands in the cycle after the read was issued.
        if (rd_pend_reg)
        begin
            out_valid_next = 1'b1;
            ch_next        = CH_W'(pend_idx_reg);
            val_next       = ram_rdata;
            good_next      = 1'b1;
            last_next      = (pend_idx_reg == LAST_IDX);
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HUNT;
            count_reg     <= '0;
            sum_reg       <= '0;
            high_reg      <= '0;
            rd_idx_reg    <= '0;
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            count_reg     <= count_next;
            sum_reg       <= sum_next;
            high_reg      <= high_next;
            rd_idx_reg    <= rd_idx_next;
            rd_pend_reg   <= issue;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        pend_idx_reg <= rd_idx_reg;
        ch_reg       <= ch_next;
        val_reg      <= val_next;
        good_reg     <= good_next;
        last_reg     <= last_next;
    end

    // Reading store.
    psfp_ram #(
        .WIDTH (VAL_W),
        .DEPTH (READING_COUNT)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (issue),
        .raddr (rd_idx_reg),
        .rdata (ram_rdata)
    );

    assign out_valid     = out_valid_reg;
    assign channel       = ch_reg;
    assign reading       = val_reg;
    assign checksum_good = good_reg;
    assign last_of_frame = last_reg;

endmodule

>>> rtl/psfp_checker.sv
// Port-level checker for the particle sensor frame parser, bound to the top level.
module psfp_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_ready,
    input logic [7:0]                 rx_byte,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic [psfp_pkg::CH_W-1:0]  channel,
    input logic [psfp_pkg::VAL_W-1:0] reading,
    input logic                       checksum_good,
    input logic                       last_of_frame
);
    import psfp_pkg::*;

    // A stalled result request holds its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(channel) && $stable(reading)
            && $stable(checksum_good) && $stable(last_of_frame))
        else $error("stalled result changed");

    // A bad frame gives one zero result that closes the frame.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !checksum_good |-> last_of_frame && channel == '0 && reading == '0)
        else $error("bad frame result malformed");

    // In a good burst the last mark sits on the final channel only.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && checksum_good |->
            (last_of_frame == (int'(channel) == READING_COUNT - 1)))
        else $error("last mark misplaced");

    // No byte is taken while a good burst is still under way.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && checksum_good && !last_of_frame |-> !in_ready)
        else $error("byte taken during burst");

endmodule

bind particle_sensor_frame_parser_core psfp_checker u_psfp_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .rx_byte       (rx_byte),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .channel       (channel),
    .reading       (reading),
    .checksum_good (checksum_good),
    .last_of_frame (last_of_frame)
);
